### sv/asirs_pkg.sv
`timescale 1ns / 1ps
package asirs_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_CHIP_ID      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_VALUE           = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONF_VALUE            = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHIP_ID_MAX_ATTEMPTS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHIP_ID_RETRY_WAIT_MS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERIFY_MAX_ATTEMPTS   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERIFY_RETRY_WAIT_MS  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_UP_SETTLE_MS    = 3'd7;

   localparam logic [7:0]  RST_EXPECTED_CHIP_ID      = 8'd30;
   localparam logic [7:0]  RST_RANGE_VALUE           = 8'd1;
   localparam logic [7:0]  RST_CONF_VALUE            = 8'd168;
   localparam logic [7:0]  RST_CHIP_ID_MAX_ATTEMPTS  = 8'd5;
   localparam logic [15:0] RST_CHIP_ID_RETRY_WAIT_MS = 16'd10;
   localparam logic [7:0]  RST_VERIFY_MAX_ATTEMPTS   = 8'd5;
   localparam logic [15:0] RST_VERIFY_RETRY_WAIT_MS  = 16'd5;
   localparam logic [15:0] RST_POWER_UP_SETTLE_MS    = 16'd1;

   localparam logic [1:0] CMD_RESTART = 2'd0;
   localparam logic [1:0] CMD_TICK    = 2'd1;
   localparam logic [1:0] CMD_START   = 2'd2;
   localparam logic [1:0] CMD_POLL    = 2'd3;

   localparam logic [1:0] LINK_OK   = 2'd0;
   localparam logic [1:0] LINK_BUSY = 2'd1;

   localparam logic [1:0] MODE_INIT  = 2'd0;
   localparam logic [1:0] MODE_READY = 2'd1;
   localparam logic [1:0] MODE_ERROR = 2'd2;

   localparam logic [3:0] ST_CHIP_ID  = 4'd0;
   localparam logic [3:0] ST_PWR_CONF = 4'd1;
   localparam logic [3:0] ST_PWR_CTRL = 4'd2;
   localparam logic [3:0] ST_RANGE    = 4'd3;
   localparam logic [3:0] ST_CONF     = 4'd4;
   localparam logic [3:0] ST_INT_IO   = 4'd5;
   localparam logic [3:0] ST_INT_MAP  = 4'd6;
   localparam logic [3:0] ST_VER_CORE = 4'd7;
   localparam logic [3:0] ST_VER_IO   = 4'd8;
   localparam logic [3:0] ST_VER_MAP  = 4'd9;
   localparam logic [3:0] ST_DATA     = 4'd10;

   localparam logic [7:0] RD_FLAG      = 8'h80;
   localparam logic [7:0] REG_CHIP_ID  = 8'h00;
   localparam logic [7:0] REG_DATA     = 8'h12;
   localparam logic [7:0] REG_CONF     = 8'h40;
   localparam logic [7:0] REG_RANGE    = 8'h41;
   localparam logic [7:0] REG_INT_IO   = 8'h53;
   localparam logic [7:0] REG_INT_MAP  = 8'h58;
   localparam logic [7:0] REG_PWR_CONF = 8'h7C;
   localparam logic [7:0] REG_PWR_CTRL = 8'h7D;

   localparam logic [7:0] VAL_PWR_ACTIVE = 8'h00;
   localparam logic [7:0] VAL_ACC_ON     = 8'h04;
   localparam logic [7:0] VAL_INT_IO     = 8'h08;
   localparam logic [7:0] VAL_INT_MAP    = 8'h04;

   localparam logic [15:0] WAIT_NONE     = 16'd0;
   localparam logic [15:0] WAIT_PWR_CONF = 16'd1;
   localparam logic [15:0] WAIT_PWR_CTRL = 16'd50;
   localparam logic [15:0] WAIT_CFG      = 16'd1;
   localparam logic [15:0] WAIT_VERIFY   = 16'd5;

   typedef struct packed {
      logic [7:0]  expected_chip_id;
      logic [7:0]  range_value;
      logic [7:0]  conf_value;
      logic [7:0]  chip_id_max_attempts;
      logic [15:0] chip_id_retry_wait_ms;
      logic [7:0]  verify_max_attempts;
      logic [15:0] verify_retry_wait_ms;
      logic [15:0] power_up_settle_ms;
   } cfg_type;

   typedef struct packed {
      logic [7:0] addr;
      logic [7:0] data;
      logic [3:0] len;
   } xfer_type;

   function automatic xfer_type xfer_for_step(input logic [3:0] step,
                                              input logic [7:0] range_value,
                                              input logic [7:0] conf_value);
      xfer_type x;
      x = '{addr: RD_FLAG | REG_DATA, data: 8'h00, len: 4'd8};
      unique case (step)
         ST_CHIP_ID:  x = '{addr: RD_FLAG | REG_CHIP_ID, data: 8'h00, len: 4'd3};
         ST_PWR_CONF: x = '{addr: REG_PWR_CONF, data: VAL_PWR_ACTIVE, len: 4'd2};
         ST_PWR_CTRL: x = '{addr: REG_PWR_CTRL, data: VAL_ACC_ON, len: 4'd2};
         ST_RANGE:    x = '{addr: REG_RANGE, data: range_value, len: 4'd2};
         ST_CONF:     x = '{addr: REG_CONF, data: conf_value, len: 4'd2};
         ST_INT_IO:   x = '{addr: REG_INT_IO, data: VAL_INT_IO, len: 4'd2};
         ST_INT_MAP:  x = '{addr: REG_INT_MAP, data: VAL_INT_MAP, len: 4'd2};
         ST_VER_CORE: x = '{addr: RD_FLAG | REG_CONF, data: 8'h00, len: 4'd4};
         ST_VER_IO:   x = '{addr: RD_FLAG | REG_INT_IO, data: 8'h00, len: 4'd3};
         ST_VER_MAP:  x = '{addr: RD_FLAG | REG_INT_MAP, data: 8'h00, len: 4'd3};
         default:     x = '{addr: RD_FLAG | REG_DATA, data: 8'h00, len: 4'd8};
      endcase
      return x;
   endfunction

endpackage

### sv/asirs_req_if.sv
`timescale 1ns / 1ps
interface asirs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [1:0]  link_status;
   logic [47:0] rx_payload;

   modport source (output valid, output command, output link_status,
                   output rx_payload, input ready);
   modport sink   (input valid, input command, input link_status,
                   input rx_payload, output ready);
endinterface

### sv/asirs_rsp_if.sv
`timescale 1ns / 1ps
interface asirs_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         run_state;
   logic               transfer_started;
   logic [7:0]         tx_address;
   logic [7:0]         tx_data;
   logic [3:0]         transfer_length;
   logic               sample_valid;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic [31:0]        read_count;
   logic [31:0]        error_count;

   modport source (output valid, output run_state, output transfer_started,
                   output tx_address, output tx_data, output transfer_length,
                   output sample_valid, output accel_x, output accel_y,
                   output accel_z, output read_count, output error_count,
                   input ready);
   modport sink   (input valid, input run_state, input transfer_started,
                   input tx_address, input tx_data, input transfer_length,
                   input sample_valid, input accel_x, input accel_y,
                   input accel_z, input read_count, input error_count,
                   output ready);
endinterface

### sv/asirs_csr.sv
`timescale 1ns / 1ps
module asirs_csr
   import asirs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_EXPECTED_CHIP_ID:      cfg_in.expected_chip_id      = csr_wdata[7:0];
            CSR_RANGE_VALUE:           cfg_in.range_value           = csr_wdata[7:0];
            CSR_CONF_VALUE:            cfg_in.conf_value            = csr_wdata[7:0];
            CSR_CHIP_ID_MAX_ATTEMPTS:  cfg_in.chip_id_max_attempts  = csr_wdata[7:0];
            CSR_CHIP_ID_RETRY_WAIT_MS: cfg_in.chip_id_retry_wait_ms = csr_wdata;
            CSR_VERIFY_MAX_ATTEMPTS:   cfg_in.verify_max_attempts   = csr_wdata[7:0];
            CSR_VERIFY_RETRY_WAIT_MS:  cfg_in.verify_retry_wait_ms  = csr_wdata;
            CSR_POWER_UP_SETTLE_MS:    cfg_in.power_up_settle_ms    = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{expected_chip_id:      RST_EXPECTED_CHIP_ID,
                     range_value:           RST_RANGE_VALUE,
                     conf_value:            RST_CONF_VALUE,
                     chip_id_max_attempts:  RST_CHIP_ID_MAX_ATTEMPTS,
                     chip_id_retry_wait_ms: RST_CHIP_ID_RETRY_WAIT_MS,
                     verify_max_attempts:   RST_VERIFY_MAX_ATTEMPTS,
                     verify_retry_wait_ms:  RST_VERIFY_RETRY_WAIT_MS,
                     power_up_settle_ms:    RST_POWER_UP_SETTLE_MS};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/accel_sensor_init_read_sequencer.sv
`timescale 1ns / 1ps
// Accelerometer bring-up and sampling sequencer. Each request carries one
// command (restart, millisecond tick, try to start a link transfer, or poll
// the running transfer) and yields exactly one response in the cycle after it is
// accepted: the run state, the transfer to launch if one was started, the
// latest sample and the read and error counters. A request is taken in every
// cycle while the response register is empty or being drained; the rate is
// set by the single next-state decision that sits between the request port
// and the response register. Configuration writes take effect in the next cycle;
// the user must make them only while no request is in flight, unchecked by the block.
module accel_sensor_init_read_sequencer
   import asirs_pkg::*;
#(
   parameter int COUNTER_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   asirs_req_if.sink              req,
   asirs_rsp_if.source            rsp
);

   cfg_type cfg;

   asirs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   logic [1:0]               mode_ff, mode_in;
   logic [3:0]               step_ff, step_in;
   logic [15:0]              wait_ff, wait_in;
   logic [15:0]              elapsed_ff, elapsed_in;
   logic                     busy_ff, busy_in;
   logic                     have_ff, have_in;
   logic [47:0]              sample_ff, sample_in;
   logic [COUNTER_WIDTH-1:0] reads_ff, reads_in;
   logic [COUNTER_WIDTH-1:0] errors_ff, errors_in;
   logic [7:0]               id_tries_ff, id_tries_in;
   logic [7:0]               ver_tries_ff, ver_tries_in;

   logic                     rsp_valid_ff;
   logic                     started_ff, started_in;
   xfer_type                 xfer_ff;
   logic [1:0]               run_state_ff;
   logic                     sample_valid_ff;
   logic [47:0]              sample_out_ff;
   logic [COUNTER_WIDTH-1:0] reads_out_ff;
   logic [COUNTER_WIDTH-1:0] errors_out_ff;

   logic     accept;
   logic     live;
   logic     wait_done;
   xfer_type xfer;
   logic [7:0] b2, b3;
   logic [7:0] id_next, ver_next;
   logic     do_fail, ver_bad;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign live      = (mode_ff == MODE_INIT) || (mode_ff == MODE_READY);
   assign wait_done = elapsed_ff >= wait_ff;
   assign xfer      = xfer_for_step(step_ff, cfg.range_value, cfg.conf_value);
   assign b2        = req.rx_payload[7:0];
   assign b3        = req.rx_payload[15:8];
   assign id_next   = id_tries_ff + 8'd1;
   assign ver_next  = ver_tries_ff + 8'd1;

   always_comb begin
      mode_in      = mode_ff;
      step_in      = step_ff;
      wait_in      = wait_ff;
      elapsed_in   = elapsed_ff;
      busy_in      = busy_ff;
      have_in      = have_ff;
      sample_in    = sample_ff;
      reads_in     = reads_ff;
      errors_in    = errors_ff;
      id_tries_in  = id_tries_ff;
      ver_tries_in = ver_tries_ff;
      started_in   = 1'b0;
      do_fail      = 1'b0;
      ver_bad      = 1'b0;

      unique case (req.command)
         CMD_RESTART: begin
            mode_in      = MODE_INIT;
            step_in      = ST_CHIP_ID;
            wait_in      = cfg.power_up_settle_ms;
            elapsed_in   = '0;
            busy_in      = 1'b0;
            have_in      = 1'b0;
            sample_in    = '0;
            reads_in     = '0;
            errors_in    = '0;
            id_tries_in  = '0;
            ver_tries_in = '0;
         end
         CMD_TICK: begin
            if (elapsed_ff != 16'hFFFF) begin
               elapsed_in = elapsed_ff + 16'd1;
            end
         end
         CMD_START: begin
            if (live && !busy_ff && wait_done) begin
               if (req.link_status == LINK_OK) begin
                  busy_in    = 1'b1;
                  started_in = 1'b1;
               end else if (req.link_status != LINK_BUSY) begin
                  do_fail = 1'b1;
               end
            end
         end
         CMD_POLL: begin
            if (live && busy_ff) begin
               if (req.link_status == LINK_OK) begin
                  busy_in    = 1'b0;
                  elapsed_in = '0;
                  unique case (step_ff)
                     ST_CHIP_ID: begin
                        if (b2 != cfg.expected_chip_id) begin
                           id_tries_in = id_next;
                           if (id_next < cfg.chip_id_max_attempts) begin
                              wait_in = cfg.chip_id_retry_wait_ms;
                           end else begin
                              elapsed_in = elapsed_ff;
                              do_fail    = 1'b1;
                           end
                        end else begin
                           id_tries_in = '0;
                           step_in     = ST_PWR_CONF;
                           wait_in     = WAIT_NONE;
                        end
                     end
                     ST_PWR_CONF: begin
                        step_in = ST_PWR_CTRL;
                        wait_in = WAIT_PWR_CONF;
                     end
                     ST_PWR_CTRL: begin
                        step_in = ST_RANGE;
                        wait_in = WAIT_PWR_CTRL;
                     end
                     ST_RANGE: begin
                        step_in = ST_CONF;
                        wait_in = WAIT_CFG;
                     end
                     ST_CONF: begin
                        step_in = ST_INT_IO;
                        wait_in = WAIT_CFG;
                     end
                     ST_INT_IO: begin
                        step_in = ST_INT_MAP;
                        wait_in = WAIT_CFG;
                     end
                     ST_INT_MAP: begin
                        step_in = ST_VER_CORE;
                        wait_in = WAIT_VERIFY;
                     end
                     ST_VER_CORE: begin
                        if (b2 != cfg.conf_value || b3 != cfg.range_value) begin
                           ver_bad = 1'b1;
                        end else begin
                           step_in = ST_VER_IO;
                           wait_in = WAIT_NONE;
                        end
                     end
                     ST_VER_IO: begin
                        if (b2 != VAL_INT_IO) begin
                           ver_bad = 1'b1;
                        end else begin
                           step_in = ST_VER_MAP;
                           wait_in = WAIT_NONE;
                        end
                     end
                     ST_VER_MAP: begin
                        if (b2 != VAL_INT_MAP) begin
                           ver_bad = 1'b1;
                        end else begin
                           ver_tries_in = '0;
                           mode_in      = MODE_READY;
                           have_in      = 1'b0;
                           step_in      = ST_DATA;
                           wait_in      = WAIT_NONE;
                        end
                     end
                     default: begin
                        elapsed_in = elapsed_ff;
                        sample_in  = req.rx_payload;
                        have_in    = 1'b1;
                        reads_in   = reads_ff + COUNTER_WIDTH'(1);
                     end
                  endcase
                  if (ver_bad) begin
                     ver_tries_in = ver_next;
                     if (ver_next < cfg.verify_max_attempts) begin
                        wait_in = cfg.verify_retry_wait_ms;
                     end else begin
                        elapsed_in = elapsed_ff;
                        do_fail    = 1'b1;
                     end
                  end
               end else if (req.link_status != LINK_BUSY) begin
                  do_fail = 1'b1;
               end
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase

      if (do_fail) begin
         errors_in = errors_ff + COUNTER_WIDTH'(1);
         mode_in   = MODE_ERROR;
         busy_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_INIT;
         step_ff      <= ST_CHIP_ID;
         wait_ff      <= RST_POWER_UP_SETTLE_MS;
         elapsed_ff   <= '0;
         busy_ff      <= 1'b0;
         have_ff      <= 1'b0;
         sample_ff    <= '0;
         reads_ff     <= '0;
         errors_ff    <= '0;
         id_tries_ff  <= '0;
         ver_tries_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff      <= mode_in;
            step_ff      <= step_in;
            wait_ff      <= wait_in;
            elapsed_ff   <= elapsed_in;
            busy_ff      <= busy_in;
            have_ff      <= have_in;
            sample_ff    <= sample_in;
            reads_ff     <= reads_in;
            errors_ff    <= errors_in;
            id_tries_ff  <= id_tries_in;
            ver_tries_ff <= ver_tries_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         started_ff      <= started_in;
         xfer_ff         <= started_in ? xfer : '0;
         run_state_ff    <= mode_in;
         sample_valid_ff <= have_in;
         sample_out_ff   <= have_in ? sample_in : '0;
         reads_out_ff    <= reads_in;
         errors_out_ff   <= errors_in;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.run_state        = run_state_ff;
   assign rsp.transfer_started = started_ff;
   assign rsp.tx_address       = xfer_ff.addr;
   assign rsp.tx_data          = xfer_ff.data;
   assign rsp.transfer_length  = xfer_ff.len;
   assign rsp.sample_valid     = sample_valid_ff;
   assign rsp.accel_x          = sample_out_ff[15:0];
   assign rsp.accel_y          = sample_out_ff[31:16];
   assign rsp.accel_z          = sample_out_ff[47:32];

   generate
      if (COUNTER_WIDTH >= 32) begin : g_cnt_wide
         assign rsp.read_count  = reads_out_ff[31:0];
         assign rsp.error_count = errors_out_ff[31:0];
      end else begin : g_cnt_narrow
         assign rsp.read_count  = 32'(reads_out_ff);
         assign rsp.error_count = 32'(errors_out_ff);
      end
   endgenerate

endmodule
